FILE: sv/vrfc_pkg.sv
// Shared types, codes and helpers for the VRPTW route feasibility checker.
package vrfc_pkg;

  localparam int DEF_MAX_NODES  = 1024;
  localparam int DEF_TIME_WIDTH = 24;
  localparam int EPOCH_W        = 8;

  localparam logic [1:0] MODE_VISIT  = 2'd0;
  localparam logic [1:0] MODE_RETURN = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_VEHICLES  = 3'd1;
  localparam logic [2:0] ERR_TIME      = 3'd2;
  localparam logic [2:0] ERR_CAPACITY  = 3'd3;
  localparam logic [2:0] ERR_VISITS    = 3'd4;
  localparam logic [2:0] ERR_MALFORMED = 3'd5;

  localparam logic [2:0] CFG_NODE_COUNT   = 3'd0;
  localparam logic [2:0] CFG_MAX_VEHICLES = 3'd1;
  localparam logic [2:0] CFG_CAPACITY     = 3'd2;
  localparam logic [2:0] CFG_DEPOT_READY  = 3'd3;
  localparam logic [2:0] CFG_DEPOT_DUE    = 3'd4;

  localparam logic [10:0] ROUTES_OUT_MAX = 11'd1024;
  localparam logic [10:0] COUNTER_MAX    = 11'd2047;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  node;
    logic [15:0] edge_cost;
    logic [23:0] ready_time;
    logic [23:0] due_time;
    logic [15:0] service_time;
    logic [15:0] demand;
  } vrfc_in_t;

  typedef struct packed {
    logic        feasible;
    logic [2:0]  error_code;
    logic [31:0] total_cost;
    logic [10:0] routes_seen;
  } vrfc_out_t;

  function automatic logic [31:0] sat32(input logic [33:0] v);
    sat32 = (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

FILE: sv/vrfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vrfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/vrptw_route_feasibility_checker.sv
// Top level of the VRPTW route feasibility checker: one stop word per cycle unless stalled.
//
//   channel | signals                               | direction | word
//   in      | in_valid_i, in_ready_o, in_data_i     | sink      | vrfc_in_t stop
//   out     | out_valid_o, out_ready_i, out_data_o  | source    | vrfc_out_t verdict
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,| sink      | register write
//           | cfg_data_i                            |           |
//
// A stop word is registered, then checked and retired; one word per cycle unless stalled.
// The visited bitmap is a RAM tagged with a solution epoch; the read is issued at accept.
// After reset in_ready_o is low while the bitmap is cleared; after every 2^EPOCH_W finish
// words in_ready_o is low from the retiring finish word on until the bitmap is cleared again.
// cfg writes are taken at all times.
// A finish word stalls only while the verdict register is full and not being taken.
module vrptw_route_feasibility_checker #(
  parameter int MAX_NODES  = vrfc_pkg::DEF_MAX_NODES,
  parameter int TIME_WIDTH = vrfc_pkg::DEF_TIME_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vrfc_pkg::vrfc_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vrfc_pkg::vrfc_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import vrfc_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int TW = (TIME_WIDTH < 24) ? TIME_WIDTH : 24;
  localparam logic [23:0] TMASK = 24'((64'd1 << TW) - 64'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // config registers
  logic [10:0] node_count_q, max_vehicles_q;
  logic [19:0] capacity_q;
  logic [23:0] depot_ready_q, depot_due_q;

  // route state
  logic [31:0] arrival_q, arrival_d;
  logic [31:0] load_q, load_d;
  logic [15:0] last_service_q, last_service_d;
  logic        route_open_q, route_open_d;
  logic [10:0] route_cnt_q, route_cnt_d;
  logic [10:0] visited_total_q, visited_total_d;
  logic [31:0] cost_sum_q, cost_sum_d;
  logic [2:0]  first_error_q, first_error_d;

  // pipeline and bitmap control
  vrfc_in_t     s1_q;
  logic         s1_valid_q;
  vrfc_out_t    out_q, out_d;
  logic         out_valid_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic         clear_q;
  logic [AW-1:0] clr_cnt_q;
  logic         fwd_hit_q, fwd_par_q;

  logic         in_fire, s1_fire, s1_adv, wrap_blk;
  logic         is_visit, is_return, is_finish, in_range;
  logic [AW-1:0] rd_addr, s1_addr;
  logic [EPOCH_W:0] rd_word;
  logic         par_eff, was_visited, vis_we;
  logic         ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EPOCH_W:0] ram_wdata;

  logic [23:0] ready_m, due_m;
  logic [33:0] leg_sum, vbase, vmax, ret_max, load_sum;
  logic [31:0] arr_new, load_new, ret_t;
  logic [2:0]  err_new, fin_code;

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q   <= 11'd1;
      max_vehicles_q <= 11'd1024;
      capacity_q     <= '0;
      depot_ready_q  <= '0;
      depot_due_q    <= 24'hFF_FFFF;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NODE_COUNT:   node_count_q   <= cfg_data_i[10:0];
        CFG_MAX_VEHICLES: max_vehicles_q <= cfg_data_i[10:0];
        CFG_CAPACITY:     capacity_q     <= cfg_data_i[19:0];
        CFG_DEPOT_READY:  depot_ready_q  <= cfg_data_i;
        CFG_DEPOT_DUE:    depot_due_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign is_visit  = (s1_q.mode == MODE_VISIT);
  assign is_return = (s1_q.mode == MODE_RETURN);
  assign is_finish = (s1_q.mode == MODE_FINISH);

  assign s1_adv   = s1_valid_q && (!is_finish || !out_valid_q || out_ready_i);
  assign s1_fire  = s1_adv;
  assign wrap_blk = s1_valid_q && is_finish && (epoch_q == EPOCH_MAX);
  assign in_ready_o = !clear_q && !wrap_blk && (!s1_valid_q || s1_adv);
  assign in_fire  = in_valid_i && in_ready_o;

  // visited bitmap: word is {epoch tag, toggle parity}
  assign rd_addr = AW'(in_data_i.node);
  assign s1_addr = AW'(s1_q.node);
  assign in_range = ({1'b0, s1_q.node} < node_count_q) &&
                    (32'(s1_q.node) < 32'(MAX_NODES));

  assign par_eff = fwd_hit_q ? fwd_par_q
                             : ((rd_word[EPOCH_W:1] == epoch_q) && rd_word[0]);
  assign was_visited = par_eff ^ (s1_q.node == 10'd0);
  assign vis_we = s1_fire && is_visit && in_range;

  assign ram_we    = clear_q || vis_we;
  assign ram_waddr = clear_q ? clr_cnt_q : s1_addr;
  assign ram_wdata = clear_q ? {epoch_q, 1'b0} : {epoch_q, !par_eff};

  vrfc_ram #(
    .WIDTH (EPOCH_W + 1),
    .DEPTH (MAX_NODES)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (rd_word)
  );

  // datapath
  assign ready_m  = s1_q.ready_time & TMASK;
  assign due_m    = s1_q.due_time & TMASK;
  assign leg_sum  = 34'(arrival_q) + 34'(last_service_q) + 34'(s1_q.edge_cost);
  assign vbase    = route_open_q ? leg_sum : 34'(s1_q.edge_cost);
  assign vmax     = (vbase < 34'(ready_m)) ? 34'(ready_m) : vbase;
  assign arr_new  = sat32(vmax);
  assign load_sum = (route_open_q ? 34'(load_q) : 34'd0) + 34'(s1_q.demand);
  assign load_new = sat32(load_sum);
  assign ret_max  = (leg_sum < 34'(depot_ready_q)) ? 34'(depot_ready_q) : leg_sum;
  assign ret_t    = sat32(ret_max);

  always_comb begin
    if (32'(route_cnt_q) > 32'(max_vehicles_q)) begin
      fin_code = ERR_VEHICLES;
    end else if (first_error_q != ERR_NONE) begin
      fin_code = first_error_q;
    end else if (route_open_q) begin
      fin_code = ERR_MALFORMED;
    end else if (visited_total_q != node_count_q) begin
      fin_code = ERR_VISITS;
    end else begin
      fin_code = ERR_NONE;
    end
  end

  always_comb begin
    arrival_d       = arrival_q;
    load_d          = load_q;
    last_service_d  = last_service_q;
    route_open_d    = route_open_q;
    route_cnt_d     = route_cnt_q;
    visited_total_d = visited_total_q;
    cost_sum_d      = cost_sum_q;
    first_error_d   = first_error_q;
    err_new         = ERR_NONE;
    out_d           = out_q;
    if (s1_fire) begin
      unique case (s1_q.mode)
        MODE_VISIT: begin
          if (!in_range) begin
            err_new = ERR_MALFORMED;
          end else begin
            if (!route_open_q && (route_cnt_q != COUNTER_MAX)) begin
              route_cnt_d = route_cnt_q + 11'd1;
            end
            route_open_d   = 1'b1;
            arrival_d      = arr_new;
            load_d         = load_new;
            last_service_d = s1_q.service_time;
            visited_total_d = was_visited ? visited_total_q - 11'd1
                                          : visited_total_q + 11'd1;
            cost_sum_d = sat32(34'(cost_sum_q) + 34'(s1_q.edge_cost));
            priority if (arr_new > 32'(due_m)) begin
              err_new = ERR_TIME;
            end else if (load_new > 32'(capacity_q)) begin
              err_new = ERR_CAPACITY;
            end
          end
        end
        MODE_RETURN: begin
          if (!route_open_q) begin
            err_new = ERR_MALFORMED;
          end else begin
            cost_sum_d     = sat32(34'(cost_sum_q) + 34'(s1_q.edge_cost));
            arrival_d      = '0;
            load_d         = '0;
            last_service_d = '0;
            route_open_d   = 1'b0;
            if (ret_t > 32'(depot_due_q)) begin
              err_new = ERR_TIME;
            end
          end
        end
        MODE_FINISH: begin
          out_d.feasible   = (fin_code == ERR_NONE);
          out_d.error_code = fin_code;
          out_d.total_cost = cost_sum_q;
          out_d.routes_seen = (route_cnt_q > ROUTES_OUT_MAX) ? ROUTES_OUT_MAX : route_cnt_q;
          arrival_d       = '0;
          load_d          = '0;
          last_service_d  = '0;
          route_open_d    = 1'b0;
          route_cnt_d     = '0;
          visited_total_d = 11'd1;
          cost_sum_d      = '0;
        end
        default: ;
      endcase
      if (is_finish) begin
        first_error_d = ERR_NONE;
      end else if (first_error_q == ERR_NONE) begin
        first_error_d = err_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q       <= '0;
      load_q          <= '0;
      last_service_q  <= '0;
      route_open_q    <= 1'b0;
      route_cnt_q     <= '0;
      visited_total_q <= 11'd1;
      cost_sum_q      <= '0;
      first_error_q   <= ERR_NONE;
    end else begin
      arrival_q       <= arrival_d;
      load_q          <= load_d;
      last_service_q  <= last_service_d;
      route_open_q    <= route_open_d;
      route_cnt_q     <= route_cnt_d;
      visited_total_q <= visited_total_d;
      cost_sum_q      <= cost_sum_d;
      first_error_q   <= first_error_d;
    end
  end

  // input stage, forwarding, output register, clear pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
      fwd_par_q   <= 1'b0;
      epoch_q     <= '0;
      clear_q     <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= vis_we && (s1_addr == rd_addr);
        fwd_par_q  <= !par_eff;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && is_finish) begin
        out_valid_q <= 1'b1;
        epoch_q     <= epoch_q + EPOCH_W'(1);
        if (epoch_q == EPOCH_MAX) begin
          clear_q   <= 1'b1;
          clr_cnt_q <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (clear_q) begin
        if (clr_cnt_q == LAST_ADDR) begin
          clear_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (s1_fire && is_finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vis_we |-> !clear_q)
    else $error("bitmap update during clear pass");

  a_finish_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && is_finish) |=> out_valid_o)
    else $error("finish word retired without verdict");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && is_finish) |=> (first_error_q == ERR_NONE) && !route_open_q &&
                               (cost_sum_q == 32'd0) && (visited_total_q == 11'd1))
    else $error("store not cleared after finish");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((first_error_q != ERR_NONE) && !(s1_fire && is_finish)) |=>
      (first_error_q == $past(first_error_q)))
    else $error("latched error changed");

  a_visited_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visited_total_q <= 11'd1024)
    else $error("visited count out of range");

endmodule
